@@ rtl/mrp_pkg.sv @@
package mrp_pkg;

   localparam int unsigned TOPIC_MAX_DEF   = 63;
   localparam int unsigned PAYLOAD_MAX_DEF = 127;

   typedef enum logic [7:0] {
      PH_HEADER  = 8'b0000_0001,
      PH_OTHER   = 8'b0000_0010,
      PH_VARINT  = 8'b0000_0100,
      PH_TLEN    = 8'b0000_1000,
      PH_TOPIC   = 8'b0001_0000,
      PH_IDENT   = 8'b0010_0000,
      PH_PAYLOAD = 8'b0100_0000,
      PH_DRAIN   = 8'b1000_0000
   } phase_type;

   localparam logic [1:0] KIND_TOPIC   = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_SUMMARY = 2'd2;

   localparam logic [3:0] PT_CONNACK  = 4'd2;
   localparam logic [3:0] PT_PUBLISH  = 4'd3;
   localparam logic [3:0] PT_PUBACK   = 4'd4;
   localparam logic [3:0] PT_SUBACK   = 4'd9;
   localparam logic [3:0] PT_UNSUBACK = 4'd11;
   localparam logic [3:0] PT_PINGRESP = 4'd13;

   localparam logic [3:0] EV_SHORT         = 4'd0;
   localparam logic [3:0] EV_TRUNCATED     = 4'd1;
   localparam logic [3:0] EV_PUBLISH       = 4'd2;
   localparam logic [3:0] EV_ACCEPTED      = 4'd3;
   localparam logic [3:0] EV_REFUSED       = 4'd4;
   localparam logic [3:0] EV_CONNACK_SHORT = 4'd5;
   localparam logic [3:0] EV_PUBACK        = 4'd6;
   localparam logic [3:0] EV_SUBACK_OK     = 4'd7;
   localparam logic [3:0] EV_SUBACK_FAIL   = 4'd8;
   localparam logic [3:0] EV_SUBACK_NOCODE = 4'd9;
   localparam logic [3:0] EV_UNSUBACK      = 4'd10;
   localparam logic [3:0] EV_PINGRESP      = 4'd11;
   localparam logic [3:0] EV_UNKNOWN       = 4'd12;

   localparam logic [7:0] SUBACK_MAX_OK = 8'd2;

   typedef struct packed {
      logic [3:0]  packet_type;
      logic [3:0]  event_code;
      logic [7:0]  reply_code;
      logic [1:0]  qos_level;
      logic [15:0] packet_ident;
      logic        ack_needed;
      logic [27:0] remaining_len;
      logic [15:0] topic_len;
      logic        session_up;
   } summary_type;

   // one queue entry: the data item and/or the summary caused by one byte
   typedef struct packed {
      logic        has_data;
      logic [1:0]  data_kind;
      logic [7:0]  data_byte;
      logic        has_sum;
      summary_type sum;
   } entry_type;

endpackage

@@ rtl/mrp_req_if.sv @@
interface mrp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] segment_byte;
   logic       segment_end;

   modport source (output valid, output segment_byte, output segment_end, input ready);
   modport sink (input valid, input segment_byte, input segment_end, output ready);
endinterface

@@ rtl/mrp_rsp_if.sv @@
interface mrp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic [7:0]  byte_out;
   logic [3:0]  packet_type;
   logic [3:0]  event_code;
   logic [7:0]  reply_code;
   logic [1:0]  qos_level;
   logic [15:0] packet_ident;
   logic        ack_needed;
   logic [27:0] remaining_len;
   logic [15:0] topic_len;
   logic        session_up;
   logic        run_last;

   modport source (output valid, output result_kind, output byte_out, output packet_type,
                   output event_code, output reply_code, output qos_level,
                   output packet_ident, output ack_needed, output remaining_len,
                   output topic_len, output session_up, output run_last, input ready);
   modport sink (input valid, input result_kind, input byte_out, input packet_type,
                 input event_code, input reply_code, input qos_level,
                 input packet_ident, input ack_needed, input remaining_len,
                 input topic_len, input session_up, input run_last, output ready);
endinterface

@@ rtl/mqtt_receive_packet_parser.sv @@
// MQTT 3.1.1 receive parser, one packet at the start of each TCP segment.
// req channel: one segment byte per item, segment_end set on the last byte.
// rsp channel: topic bytes (kind 0), payload bytes (kind 1) and one summary
// (kind 2) per segment; run_last marks the last item caused by a byte.
// Items caused by a byte are registered in the output queue when the byte is
// accepted. Throughput: one byte per cycle while req.ready is high; the final
// byte of a segment may cause a data item plus the summary, shown as two rsp
// items. Each byte is parsed combinationally against the phase registers and
// the result is written to a two-entry output queue, so req keeps flowing
// while rsp is stalled until both entries hold results; then req.ready drops.
// Reset (synchronous) clears the parser to the header phase, clears the
// connected flag and empties the queue.
// TOPIC_MAX caps streamed topic bytes (extra bytes are parsed as the fields
// that follow); PAYLOAD_MAX caps payload bytes (extra bytes are dropped).
module mqtt_receive_packet_parser
   import mrp_pkg::*;
#(
   parameter int unsigned TOPIC_MAX   = TOPIC_MAX_DEF,
   parameter int unsigned PAYLOAD_MAX = PAYLOAD_MAX_DEF
) (
   input logic        clock,
   input logic        reset,
   mrp_req_if.sink    req,
   mrp_rsp_if.source  rsp
);

   localparam int unsigned TW = $clog2(TOPIC_MAX + 1);
   localparam int unsigned PW = $clog2(PAYLOAD_MAX + 1);
   localparam logic [TW-1:0] TOPIC_LIM = TW'(TOPIC_MAX);
   localparam logic [PW-1:0] PAY_LIM   = PW'(PAYLOAD_MAX);

   // parser state
   phase_type      phase_ff, phase_in;
   logic [15:0]    bidx_ff, bidx_in;
   logic [7:0]     first_ff, first_in;
   logic [27:0]    accum_ff, accum_in;
   logic [2:0]     vcnt_ff, vcnt_in;
   logic [15:0]    tlen_ff, tlen_in;
   logic [TW-1:0]  ttaken_ff, ttaken_in;
   logic [15:0]    ident_ff, ident_in;
   logic           half_ff, half_in;
   logic [PW-1:0]  ptaken_ff, ptaken_in;
   logic [7:0]     code_ff, code_in;
   logic           conn_ff, conn_in;

   // output queue
   entry_type      fifo_mem [2];
   logic           wr_ptr_ff, rd_ptr_ff, sub_ff;
   logic [1:0]     cnt_ff;

   logic           accept, push, pop_item, pop_entry, show_data;
   logic           data_vld, take_pay;
   logic [1:0]     data_kind;
   logic [3:0]     ptype;
   phase_type      leave_phase;
   summary_type    sum;
   entry_type      new_entry, head;

   assign accept      = req.valid && req.ready;
   assign req.ready   = (cnt_ff != 2'd2);
   assign leave_phase = (first_ff[2:1] != 2'd0) ? PH_IDENT : PH_PAYLOAD;

   always_comb begin
      phase_in  = phase_ff;
      bidx_in   = (bidx_ff != 16'hFFFF) ? bidx_ff + 16'd1 : bidx_ff;
      first_in  = first_ff;
      accum_in  = accum_ff;
      vcnt_in   = vcnt_ff;
      tlen_in   = tlen_ff;
      ttaken_in = ttaken_ff;
      ident_in  = ident_ff;
      half_in   = half_ff;
      ptaken_in = ptaken_ff;
      code_in   = code_ff;
      data_vld  = 1'b0;
      data_kind = KIND_TOPIC;
      take_pay  = 1'b0;

      unique case (phase_ff)
         PH_HEADER: begin
            first_in = req.segment_byte;
            phase_in = (req.segment_byte[7:4] == PT_PUBLISH) ? PH_VARINT : PH_OTHER;
         end
         PH_OTHER: begin
            if ((first_ff[7:4] == PT_CONNACK && bidx_ff == 16'd3) ||
                (first_ff[7:4] == PT_SUBACK && bidx_ff == 16'd4)) begin
               code_in = req.segment_byte;
            end
         end
         PH_VARINT: begin
            // bytes after the fourth are consumed but not accumulated
            if (vcnt_ff < 3'd4) begin
               case (vcnt_ff[1:0])
                  2'd0: accum_in[6:0]   = accum_ff[6:0]   | req.segment_byte[6:0];
                  2'd1: accum_in[13:7]  = accum_ff[13:7]  | req.segment_byte[6:0];
                  2'd2: accum_in[20:14] = accum_ff[20:14] | req.segment_byte[6:0];
                  default: accum_in[27:21] = accum_ff[27:21] | req.segment_byte[6:0];
               endcase
               vcnt_in = vcnt_ff + 3'd1;
            end
            if (!req.segment_byte[7]) begin
               phase_in = PH_TLEN;
            end
         end
         PH_TLEN: begin
            if (!half_ff) begin
               tlen_in = {req.segment_byte, 8'h00};
               half_in = 1'b1;
            end else begin
               tlen_in  = tlen_ff | {8'h00, req.segment_byte};
               half_in  = 1'b0;
               phase_in = (tlen_in == 16'd0) ? leave_phase : PH_TOPIC;
            end
         end
         PH_TOPIC: begin
            data_vld  = 1'b1;
            data_kind = KIND_TOPIC;
            ttaken_in = ttaken_ff + TW'(1);
            if (16'(ttaken_in) >= tlen_ff || ttaken_in >= TOPIC_LIM) begin
               phase_in = leave_phase;
            end
         end
         PH_IDENT: begin
            if (!half_ff) begin
               // lone byte where the id would be is payload
               if (req.segment_end) begin
                  take_pay = 1'b1;
               end else begin
                  ident_in = {req.segment_byte, 8'h00};
                  half_in  = 1'b1;
               end
            end else begin
               ident_in = ident_ff | {8'h00, req.segment_byte};
               half_in  = 1'b0;
               phase_in = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: take_pay = 1'b1;
         PH_DRAIN: ;
         default: ;
      endcase

      if (take_pay) begin
         if (ptaken_ff < PAY_LIM) begin
            data_vld  = 1'b1;
            data_kind = KIND_PAYLOAD;
            ptaken_in = ptaken_ff + PW'(1);
         end
         if (ptaken_in >= PAY_LIM) begin
            phase_in = PH_DRAIN;
         end
      end
   end

   // end-of-segment summary from the updated state
   always_comb begin
      ptype   = first_in[7:4];
      conn_in = conn_ff;
      sum     = '0;
      sum.packet_type = ptype;
      if (bidx_in < 16'd2) begin
         sum.event_code = EV_SHORT;
      end else if (ptype == PT_PUBLISH) begin
         sum.qos_level     = first_in[2:1];
         sum.remaining_len = accum_in;
         if (phase_in == PH_VARINT || phase_in == PH_TLEN) begin
            sum.event_code = EV_TRUNCATED;
         end else begin
            sum.event_code   = EV_PUBLISH;
            sum.topic_len    = tlen_in;
            sum.packet_ident = ident_in;
            sum.ack_needed   = (first_in[2:1] == 2'd1) && (ident_in != 16'd0);
         end
      end else if (ptype == PT_CONNACK) begin
         if (bidx_in >= 16'd4) begin
            sum.reply_code = code_in;
            sum.event_code = (code_in == 8'd0) ? EV_ACCEPTED : EV_REFUSED;
            conn_in        = (code_in == 8'd0);
         end else begin
            sum.event_code = EV_CONNACK_SHORT;
         end
      end else if (ptype == PT_PUBACK) begin
         sum.event_code = EV_PUBACK;
      end else if (ptype == PT_SUBACK) begin
         if (bidx_in >= 16'd5) begin
            sum.reply_code = code_in;
            sum.event_code = (code_in <= SUBACK_MAX_OK) ? EV_SUBACK_OK : EV_SUBACK_FAIL;
         end else begin
            sum.event_code = EV_SUBACK_NOCODE;
         end
      end else if (ptype == PT_UNSUBACK) begin
         sum.event_code = EV_UNSUBACK;
      end else if (ptype == PT_PINGRESP) begin
         sum.event_code = EV_PINGRESP;
      end else begin
         sum.event_code = EV_UNKNOWN;
      end
      sum.session_up = conn_in;
   end

   always_comb begin
      new_entry           = '0;
      new_entry.has_data  = data_vld;
      new_entry.data_kind = data_kind;
      new_entry.data_byte = req.segment_byte;
      new_entry.has_sum   = req.segment_end;
      new_entry.sum       = sum;
   end

   assign push = accept && (data_vld || req.segment_end);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEADER;
         bidx_ff   <= '0;
         first_ff  <= '0;
         accum_ff  <= '0;
         vcnt_ff   <= '0;
         tlen_ff   <= '0;
         ttaken_ff <= '0;
         ident_ff  <= '0;
         half_ff   <= 1'b0;
         ptaken_ff <= '0;
         code_ff   <= '0;
         conn_ff   <= 1'b0;
      end else if (accept) begin
         if (req.segment_end) begin
            phase_ff  <= PH_HEADER;
            bidx_ff   <= '0;
            first_ff  <= '0;
            accum_ff  <= '0;
            vcnt_ff   <= '0;
            tlen_ff   <= '0;
            ttaken_ff <= '0;
            ident_ff  <= '0;
            half_ff   <= 1'b0;
            ptaken_ff <= '0;
            code_ff   <= '0;
            conn_ff   <= conn_in;
         end else begin
            phase_ff  <= phase_in;
            bidx_ff   <= bidx_in;
            first_ff  <= first_in;
            accum_ff  <= accum_in;
            vcnt_ff   <= vcnt_in;
            tlen_ff   <= tlen_in;
            ttaken_ff <= ttaken_in;
            ident_ff  <= ident_in;
            half_ff   <= half_in;
            ptaken_ff <= ptaken_in;
            code_ff   <= code_in;
         end
      end
   end

   // output queue; an entry with both items shows the data item first
   assign head      = fifo_mem[rd_ptr_ff];
   assign show_data = head.has_data && !sub_ff;
   assign rsp.valid = (cnt_ff != 2'd0);
   assign pop_item  = rsp.valid && rsp.ready;
   assign pop_entry = pop_item && !(show_data && head.has_sum);

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_mem[wr_ptr_ff] <= new_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
         sub_ff    <= 1'b0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop_entry) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         if (pop_item) begin
            sub_ff <= !pop_entry;
         end
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop_entry};
      end
   end

   always_comb begin
      rsp.result_kind   = KIND_SUMMARY;
      rsp.byte_out      = 8'd0;
      rsp.packet_type   = head.sum.packet_type;
      rsp.event_code    = head.sum.event_code;
      rsp.reply_code    = head.sum.reply_code;
      rsp.qos_level     = head.sum.qos_level;
      rsp.packet_ident  = head.sum.packet_ident;
      rsp.ack_needed    = head.sum.ack_needed;
      rsp.remaining_len = head.sum.remaining_len;
      rsp.topic_len     = head.sum.topic_len;
      rsp.session_up    = head.sum.session_up;
      rsp.run_last      = 1'b1;
      if (show_data) begin
         rsp.result_kind   = head.data_kind;
         rsp.byte_out      = head.data_byte;
         rsp.packet_type   = 4'd0;
         rsp.event_code    = 4'd0;
         rsp.reply_code    = 8'd0;
         rsp.qos_level     = 2'd0;
         rsp.packet_ident  = 16'd0;
         rsp.ack_needed    = 1'b0;
         rsp.remaining_len = 28'd0;
         rsp.topic_len     = 16'd0;
         rsp.session_up    = 1'b0;
         rsp.run_last      = !head.has_sum;
      end
   end

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("output queue count out of range");

   a_sum_last: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.result_kind == KIND_SUMMARY |-> rsp.run_last)
      else $error("summary item without run_last");

   a_data_then_sum: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.ready && rsp.result_kind != KIND_SUMMARY && !rsp.run_last
      |=> rsp.valid && rsp.result_kind == KIND_SUMMARY)
      else $error("data item not followed by its summary");

   a_data_clean: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.result_kind != KIND_SUMMARY
      |-> rsp.event_code == 4'd0 && rsp.packet_ident == 16'd0 && !rsp.session_up)
      else $error("data item carries summary fields");

endmodule
